// ===== rtl/core/tptld_pkg.sv =====
// Shared constants, register codes and table-building functions for the two-piece t log density.
package tptld_pkg;

    // Default sizes handed to the top level parameters.
    localparam int LOG_TABLE_DEPTH_DEF = 64;
    localparam int SUM_WIDTH_DEF       = 48;

    // Field and datapath widths.
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int TW_W      = 25;
    localparam int IDOF_W    = 28;
    localparam int MODE_W    = 2;
    localparam int NLL_W     = 48;
    localparam int PROD_W    = 64;
    localparam int Y_W       = 93;
    localparam int Y_FRAC    = 56;
    localparam int LZ_W      = 6;
    localparam int L_W       = 38;
    localparam int TERM_W    = 47;
    localparam int DENS_W    = 49;
    localparam int NORM_STEPS = 6;
    localparam int EXP_TOP   = Y_W - 1 - Y_FRAC;

    // Lowest log density, log(1e-100) in Q16.16.
    localparam logic signed [DATA_W-1:0] FLOOR_Q16 = -32'sd15090221;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOCATION        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_BELOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_ABOVE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BELOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ABOVE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_WEIGHT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DOF         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DENSITY_MODE    = 3'd7;

    // Density mode codes; any other code means invalid parameters.
    localparam logic [MODE_W-1:0] MODE_STUDENT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL  = 2'd1;

    // Restoring division by shift and subtract, for elaboration-time table building only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln(1 + idx/n) in Q0.32 from the series 2*atanh(idx / (2n + idx)), truncated.
    function automatic logic [31:0] ln_ratio(input int unsigned idx, input int unsigned n);
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] term;
        logic [63:0] sum;
        s    = udiv64(64'(idx) << 32, 64'(2 * n + idx));
        s2   = (s * s) >> 32;
        term = s;
        sum  = '0;
        for (int k = 1; k < 200; k += 2) begin
            if (term != 64'd0) begin
                sum  = sum + udiv64(term, 64'(k));
                term = (term * s2) >> 32;
            end
        end
        return 32'(sum << 1);
    endfunction

endpackage

// ===== rtl/core/tptld_log_tab.sv =====
// Constant table of ln(1 + i/DEPTH) with a registered base and slope lookup.
module tptld_log_tab #(
    parameter int DEPTH = tptld_pkg::LOG_TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [$clog2(DEPTH)-1:0]      i_idx,
    output logic [tptld_pkg::DATA_W-1:0]  o_base,
    output logic [tptld_pkg::DATA_W-1:0]  o_step,
    output logic [tptld_pkg::DATA_W-1:0]  o_ln2
);
    import tptld_pkg::*;

    localparam int TAB_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] w_tab [DEPTH+1];
    logic [TAB_W-1:0]  w_lo_addr;
    logic [TAB_W-1:0]  w_hi_addr;
    logic [DATA_W-1:0] r_base;
    logic [DATA_W-1:0] r_step;

    // Each entry is folded to a constant at elaboration.
    for (genvar gi = 0; gi <= DEPTH; gi++) begin : g_entry
        localparam logic [DATA_W-1:0] C_ENTRY = ln_ratio(gi, DEPTH);
        assign w_tab[gi] = C_ENTRY;
    end

    // Neighboring entries bracket the mantissa.
    assign w_lo_addr = TAB_W'(i_idx);
    assign w_hi_addr = w_lo_addr + TAB_W'(1);

    // Base value and slope of the interval, held until the next lookup.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_base <= w_tab[w_lo_addr];
            r_step <= w_tab[w_hi_addr] - w_tab[w_lo_addr];
        end
    end

    assign o_base = r_base;
    assign o_step = r_step;
    // The last entry is ln 2, the weight of one binary exponent.
    assign o_ln2  = w_tab[DEPTH];

endmodule

// ===== rtl/core/two_piece_t_log_density.sv =====
// Two-piece scaled Student-t log density with a saturating negative log-likelihood sum.
//
//  Channel   Direction  Handshake                     Payload
//  cfg       in         i_cfg_we                      i_cfg_index, i_cfg_data
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata: sample; tuser: restart
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata: log_density, neg_log_likelihood
//
// One 32x32 multiplier, stepped by the state machine, carries all products.
// A sample in Student-t mode passes through every state, with six steps that normalize the
// log argument; normal mode goes from S_Z2 to S_DENS, and invalid mode from S_IDLE to S_ACC.
// There is no table or memory clearing pass at reset.
// A result waits in the output register while the next sample is taken in and
// worked; that sample holds in its last step until the output register frees.
module two_piece_t_log_density #(
    parameter int LOG_TABLE_DEPTH = tptld_pkg::LOG_TABLE_DEPTH_DEF,
    parameter int SUM_WIDTH       = tptld_pkg::SUM_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tptld_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tptld_pkg::DATA_W-1:0]      i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tptld_pkg::DATA_W-1:0]      s_axis_tdata,  // [31:0] sample
    input  logic [0:0]                        s_axis_tuser,  // [0] restart
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [79:0]                       m_axis_tdata   // [31:0] log_density,
                                                             // [79:32] neg_log_likelihood
);
    import tptld_pkg::*;

    localparam int IDX_W = $clog2(LOG_TABLE_DEPTH);
    localparam int EXT_W = (SUM_WIDTH > NLL_W) ? SUM_WIDTH : NLL_W;
    localparam logic [Y_W-1:0] Y_ONE = {{(Y_W-Y_FRAC-1){1'b0}}, 1'b1, {Y_FRAC{1'b0}}};
    localparam logic signed [DENS_W-1:0] FLOOR_DENS = DENS_W'(FLOOR_Q16);
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_ZMUL, S_ZSQ, S_Z2, S_YLO, S_YHI, S_NORM, S_IDX,
        S_TAB, S_INT, S_LN2, S_LSUM, S_TLO, S_THI, S_DENS, S_ACC
    } t_state;

    // Configuration registers.
    logic [DATA_W-1:0] r_location;
    logic [DATA_W-1:0] r_inv_below;
    logic [DATA_W-1:0] r_inv_above;
    logic [DATA_W-1:0] r_off_below;
    logic [DATA_W-1:0] r_off_above;
    logic [TW_W-1:0]   r_tail_weight;
    logic [IDOF_W-1:0] r_inv_dof;
    logic [MODE_W-1:0] r_mode;

    // Sequencer and datapath registers.
    t_state                    r_state;
    logic                      r_restart;
    logic                      r_below;
    logic [DATA_W-1:0]         r_mag;
    logic [PROD_W-1:0]         r_prod;
    logic [DATA_W-1:0]         r_z2_hi;
    logic [59:0]               r_a;
    logic [Y_W-1:0]            r_y;
    logic [LZ_W-1:0]           r_lz;
    logic [2:0]                r_norm_cnt;
    logic [LZ_W-1:0]           r_exp;
    logic [DATA_W-1:0]         r_rem;
    logic [DATA_W-1:0]         r_lnm;
    logic [L_W-DATA_W-1:0]     r_l_hi;
    logic [TW_W-1:0]           r_t_lo;
    logic [TERM_W-1:0]         r_term;
    logic signed [DATA_W-1:0]  r_dens;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic                      r_out_valid;
    logic [79:0]               r_out_data;

    logic signed [DATA_W:0]    w_diff;
    logic [DATA_W:0]           w_neg;
    logic                      w_below;
    logic [DATA_W-1:0]         w_mag;
    logic                      w_invalid;
    logic [DATA_W-1:0]         w_inv;
    logic [DATA_W-1:0]         w_off;
    logic [DATA_W-1:0]         w_z;
    logic [DATA_W-1:0]         w_mul_a;
    logic [DATA_W-1:0]         w_mul_b;
    logic [PROD_W-1:0]         w_prod;
    logic [Y_W-1:0]            w_y;
    logic [LZ_W-1:0]           w_shamt;
    logic [Y_W-1:0]            w_top_mask;
    logic                      w_top_zero;
    logic [L_W-1:0]            w_lsum;
    logic [DATA_W-1:0]         w_tab_base;
    logic [DATA_W-1:0]         w_tab_step;
    logic [DATA_W-1:0]         w_ln2;
    logic signed [DENS_W-1:0]  w_dens;
    logic signed [SUM_WIDTH-1:0] w_sum_base;
    logic signed [SUM_WIDTH:0] w_sum_wide;
    logic signed [SUM_WIDTH-1:0] w_sum_next;
    logic signed [EXT_W-1:0]   w_sum_ext;

    // Register writes; the 3-bit index covers exactly the eight registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_location    <= '0;
            r_inv_below   <= DATA_W'(65536);
            r_inv_above   <= DATA_W'(65536);
            r_off_below   <= '0;
            r_off_above   <= '0;
            r_tail_weight <= '0;
            r_inv_dof     <= '0;
            r_mode        <= MODE_NORMAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LOCATION:        r_location    <= i_cfg_data;
                REG_INV_SCALE_BELOW: r_inv_below   <= i_cfg_data;
                REG_INV_SCALE_ABOVE: r_inv_above   <= i_cfg_data;
                REG_OFFSET_BELOW:    r_off_below   <= i_cfg_data;
                REG_OFFSET_ABOVE:    r_off_above   <= i_cfg_data;
                REG_TAIL_WEIGHT:     r_tail_weight <= i_cfg_data[TW_W-1:0];
                REG_INV_DOF:         r_inv_dof     <= i_cfg_data[IDOF_W-1:0];
                REG_DENSITY_MODE:    r_mode        <= i_cfg_data[MODE_W-1:0];
            endcase
        end
    end

    // Side of the split point and distance from it.
    assign w_diff    = $signed({s_axis_tdata[DATA_W-1], s_axis_tdata})
                     - $signed({r_location[DATA_W-1], r_location});
    assign w_neg     = -w_diff;
    assign w_below   = w_diff[DATA_W];
    assign w_mag     = w_diff[DATA_W] ? w_neg[DATA_W-1:0] : w_diff[DATA_W-1:0];
    assign w_invalid = (r_mode != MODE_STUDENT) && (r_mode != MODE_NORMAL);
    assign w_inv     = r_below ? r_inv_below : r_inv_above;
    assign w_off     = r_below ? r_off_below : r_off_above;

    // Scaled distance, saturated to 32 bits.
    assign w_z = (r_prod[PROD_W-1:48] != '0) ? '1 : r_prod[47:16];

    // Log argument 1 + z^2 * inv_dof with 56 fraction bits.
    assign w_y = Y_W'(r_a) + Y_W'({r_prod[59:0], 32'b0}) + Y_ONE;

    // Normalizing shift: 32, 16, 8, 4, 2, 1 over six steps.
    assign w_shamt    = LZ_W'(32) >> r_norm_cnt;
    assign w_top_mask = ~({Y_W{1'b1}} >> w_shamt);
    assign w_top_zero = (r_y & w_top_mask) == '0;

    // Logarithm in Q32: exponent part plus interpolated mantissa part.
    assign w_lsum = r_prod[L_W-1:0] + L_W'(r_lnm);

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = r_mag;
        w_mul_b = w_inv;
        unique case (r_state)
            S_ZSQ: begin
                w_mul_a = w_z;
                w_mul_b = w_z;
            end
            S_Z2: begin
                w_mul_a = r_prod[DATA_W-1:0];
                w_mul_b = DATA_W'(r_inv_dof);
            end
            S_YLO: begin
                w_mul_a = r_z2_hi;
                w_mul_b = DATA_W'(r_inv_dof);
            end
            S_IDX: begin
                w_mul_a = r_y[Y_W-2 -: DATA_W];
                w_mul_b = DATA_W'(LOG_TABLE_DEPTH);
            end
            S_INT: begin
                w_mul_a = w_tab_step;
                w_mul_b = r_rem;
            end
            S_LN2: begin
                w_mul_a = DATA_W'(r_exp);
                w_mul_b = w_ln2;
            end
            S_LSUM: begin
                w_mul_a = w_lsum[DATA_W-1:0];
                w_mul_b = DATA_W'(r_tail_weight);
            end
            S_TLO: begin
                w_mul_a = DATA_W'(r_l_hi);
                w_mul_b = DATA_W'(r_tail_weight);
            end
            default: begin
                w_mul_a = r_mag;
                w_mul_b = w_inv;
            end
        endcase
    end

    // Shared multiplier with its product registered every cycle.
    assign w_prod = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    tptld_log_tab #(
        .DEPTH (LOG_TABLE_DEPTH)
    ) u_log_tab (
        .i_clk  (i_clk),
        .i_load (r_state == S_TAB),
        .i_idx  (r_prod[DATA_W +: IDX_W]),
        .o_base (w_tab_base),
        .o_step (w_tab_step),
        .o_ln2  (w_ln2)
    );

    // Offset minus term, raised to the floor.
    assign w_dens = $signed({{(DENS_W-DATA_W){w_off[DATA_W-1]}}, w_off})
                  - $signed({{(DENS_W-TERM_W){1'b0}}, r_term});

    // Saturating subtraction of the density from the running sum.
    assign w_sum_base = r_restart ? '0 : r_sum;
    assign w_sum_wide = {w_sum_base[SUM_WIDTH-1], w_sum_base} - (SUM_WIDTH+1)'(r_dens);

    always_comb begin
        if (w_sum_wide[SUM_WIDTH] == w_sum_wide[SUM_WIDTH-1]) begin
            w_sum_next = w_sum_wide[SUM_WIDTH-1:0];
        end else if (w_sum_wide[SUM_WIDTH]) begin
            w_sum_next = SUM_MIN;
        end else begin
            w_sum_next = SUM_MAX;
        end
    end

    assign w_sum_ext = EXT_W'(w_sum_next);

    // Sequencer with the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
        end else begin
            // The last step loads the output register itself, so the clear stays out of it.
            if (r_out_valid && m_axis_tready && (r_state != S_ACC)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_restart <= s_axis_tuser[0];
                        r_below   <= w_below;
                        r_mag     <= w_mag;
                        if (w_invalid) begin
                            r_dens  <= FLOOR_Q16;
                            r_state <= S_ACC;
                        end else begin
                            r_state <= S_ZMUL;
                        end
                    end
                end
                S_ZMUL: begin
                    r_state <= S_ZSQ;
                end
                S_ZSQ: begin
                    r_state <= S_Z2;
                end
                S_Z2: begin
                    r_z2_hi <= r_prod[PROD_W-1:DATA_W];
                    if (r_mode == MODE_NORMAL) begin
                        r_term  <= r_prod[PROD_W-1:17];
                        r_state <= S_DENS;
                    end else begin
                        r_state <= S_YLO;
                    end
                end
                S_YLO: begin
                    r_a     <= r_prod[59:0];
                    r_state <= S_YHI;
                end
                S_YHI: begin
                    r_y        <= w_y;
                    r_lz       <= '0;
                    r_norm_cnt <= '0;
                    r_state    <= S_NORM;
                end
                S_NORM: begin
                    if (w_top_zero) begin
                        r_y  <= r_y << w_shamt;
                        r_lz <= r_lz + w_shamt;
                    end
                    r_norm_cnt <= r_norm_cnt + 3'd1;
                    if (r_norm_cnt == 3'(NORM_STEPS - 1)) begin
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    r_exp   <= LZ_W'(EXP_TOP) - r_lz;
                    r_state <= S_TAB;
                end
                S_TAB: begin
                    r_rem   <= r_prod[DATA_W-1:0];
                    r_state <= S_INT;
                end
                S_INT: begin
                    r_state <= S_LN2;
                end
                S_LN2: begin
                    r_lnm   <= w_tab_base + r_prod[PROD_W-1:DATA_W];
                    r_state <= S_LSUM;
                end
                S_LSUM: begin
                    r_l_hi  <= w_lsum[L_W-1:DATA_W];
                    r_state <= S_TLO;
                end
                S_TLO: begin
                    r_t_lo  <= r_prod[DATA_W +: TW_W];
                    r_state <= S_THI;
                end
                S_THI: begin
                    r_term  <= TERM_W'(r_t_lo) + TERM_W'(r_prod[DATA_W-2:0]);
                    r_state <= S_DENS;
                end
                S_DENS: begin
                    if (w_dens < FLOOR_DENS) begin
                        r_dens <= FLOOR_Q16;
                    end else begin
                        r_dens <= w_dens[DATA_W-1:0];
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_sum       <= w_sum_next;
                        r_out_data  <= {w_sum_ext[NLL_W-1:0], r_dens};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // A transfer starts work, so the input side closes for the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a sample is in progress");

    // After six steps the leading one of the log argument sits at the top bit.
    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDX) |-> r_y[Y_W-1])
        else $error("log argument not normalized");

    // The table index stays below the table depth.
    a_tab_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAB) |-> (r_prod[PROD_W-1:DATA_W] < DATA_W'(LOG_TABLE_DEPTH)))
        else $error("log table index out of range");

    // A finished sample waits while the output register still holds an untaken result.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && r_out_valid && !m_axis_tready) |=> (r_state == S_ACC))
        else $error("result overwrote a pending transfer");

    // No log density below the floor leaves the block.
    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[DATA_W-1:0]) >= FLOOR_Q16))
        else $error("log density below floor");
`endif

endmodule
